// ----- design/cfdf_pkg.sv -----
// Shared types, constants and helpers for the coverage first-detect fitness block.
// Used by every module of the block but cfdf_fifo; depends on nothing else.

package cfdf_pkg;

	// field widths
	localparam int StmtW     = 64;
	localparam int TimeInW   = 32;
	localparam int CntW      = 7;
	localparam int PosW      = 11;
	localparam int SumW      = 17;
	localparam int ApscW     = 17;
	localparam int EffTimeW  = 42;
	localparam int LastW     = 10;
	localparam int CfgIndexW = 2;

	// stream payload widths, padded to whole bytes
	localparam int InDataW  = 96;
	localparam int OutDataW = 152;

	// APSC divider widths: den = 2nm, dividend = num * 2^17 + den
	localparam int DenW  = 19;
	localparam int NumW  = 20;
	localparam int DvdW  = 38;
	localparam int DvsW  = 20;
	localparam int QuotW = 18;
	localparam int DivCntW = 6;

	// parameter defaults
	localparam int MaxStatementsDef = 64;
	localparam int MaxTestsDef      = 1024;

	// register reset values
	localparam logic [CntW-1:0]  StmtCountRst  = 7'd64;
	localparam logic [PosW-1:0]  TestCountRst  = 11'd1024;
	localparam logic [StmtW-1:0] StmtEnableRst = '1;

	// saturation limits
	localparam logic [SumW-1:0]     SumMax  = '1;
	localparam logic [EffTimeW-1:0] TimeMax = '1;
	localparam logic [LastW-1:0]    LastMax = '1;
	localparam logic [ApscW-1:0]    ApscMax = 17'd98304;

	// configuration register indexes
	typedef enum logic [CfgIndexW-1:0] {
		CFG_STMT_COUNT  = 2'd0,
		CFG_TEST_COUNT  = 2'd1,
		CFG_STMT_ENABLE = 2'd2
	} cfg_index_t;

	// effective counts after clamping, shared by front and back
	typedef struct packed {
		logic [CntW-1:0] n_eff;
		logic [PosW-1:0] m_eff;
	} counts_t;

	// one classified test, front to back
	typedef struct packed {
		logic [CntW-1:0]    fresh_count;
		logic [PosW-1:0]    pos;
		logic [TimeInW-1:0] time_val;
		logic               last;
		logic [StmtW-1:0]   uncovered;
	} item_t;

	localparam int ItemW = $bits(item_t);

	// back end sequencer
	typedef enum logic [2:0] {
		B_RUN,
		B_PREP,
		B_SETUP,
		B_DIV,
		B_OUT
	} back_state_t;

	// population count as eight byte counts summed together
	function automatic logic [CntW-1:0] popcount64(input logic [StmtW-1:0] v);
		logic [3:0]      part [8];
		logic [CntW-1:0] total;
		total = '0;
		for (int g = 0; g < 8; g++) begin
			part[g] = '0;
			for (int b = 0; b < 8; b++) begin
				part[g] = part[g] + 4'(v[g*8+b]);
			end
		end
		for (int g = 0; g < 8; g++) begin
			total = total + CntW'(part[g]);
		end
		return total;
	endfunction

endpackage

// ----- design/cfdf_fifo.sv -----
// Small flop-based queue between the front and back ends.
// Standalone; no package dependency.

module cfdf_fifo #(
	parameter int Width = 8,
	parameter int Depth = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [Width-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [Width-1:0] pop_data
);

	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CountW = $clog2(Depth + 1);

	logic [Width-1:0]  mem_q [Depth];
	logic [AddrW-1:0]  wr_ptr_q;
	logic [AddrW-1:0]  rd_ptr_q;
	logic [CountW-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != CountW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// storage, no reset
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/cfdf_front.sv -----
// Front end: accepts tests, finds newly covered statements and tags the end of an ordering.
// Depends on cfdf_pkg.

module cfdf_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [cfdf_pkg::StmtW-1:0]    coverage_bits,
	input  logic [cfdf_pkg::TimeInW-1:0]  test_time,
	input  cfdf_pkg::counts_t             counts,
	input  logic [cfdf_pkg::StmtW-1:0]    stmt_enable,
	output logic                          push_valid,
	input  logic                          push_ready,
	output cfdf_pkg::item_t               push_item
);

	import cfdf_pkg::*;

	logic [StmtW-1:0] covered_q;
	logic [PosW-1:0]  pos_q;
	logic [StmtW-1:0] low_mask;
	logic [StmtW-1:0] fresh;
	logic [PosW:0]    pos_next;
	logic             is_last;
	logic             accept;

	// statements below n
	always_comb begin
		for (int i = 0; i < StmtW; i++) begin
			low_mask[i] = (CntW'(i) < counts.n_eff);
		end
	end

	assign fresh    = coverage_bits & stmt_enable & low_mask & ~covered_q;
	assign pos_next = {1'b0, pos_q} + 1'b1;
	assign is_last  = (pos_next >= {1'b0, counts.m_eff});

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	// classified transaction toward the back end
	always_comb begin
		push_item.fresh_count = popcount64(fresh);
		push_item.pos         = pos_q;
		push_item.time_val    = test_time;
		push_item.last        = is_last;
		push_item.uncovered   = ~(covered_q | fresh);
	end

	// coverage and position tracking, cleared at end of ordering
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			covered_q <= '0;
			pos_q     <= '0;
		end else if (accept) begin
			if (is_last) begin
				covered_q <= '0;
				pos_q     <= '0;
			end else begin
				covered_q <= covered_q | fresh;
				pos_q     <= pos_next[PosW-1:0];
			end
		end
	end

endmodule

// ----- design/cfdf_back.sv -----
// Back end: accumulates sums and times, then computes APSC with a bit-serial divider.
// Depends on cfdf_pkg.

module cfdf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  cfdf_pkg::item_t                pop_item,
	input  cfdf_pkg::counts_t              counts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cfdf_pkg::SumW-1:0]      position_sum,
	output logic [cfdf_pkg::ApscW-1:0]     apsc_value,
	output logic [cfdf_pkg::EffTimeW-1:0]  effective_time,
	output logic [cfdf_pkg::LastW-1:0]     last_detect_position,
	output logic [cfdf_pkg::StmtW-1:0]     uncovered_mask
);

	import cfdf_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	// accumulators
	logic [SumW-1:0]     sum_q;
	logic [EffTimeW-1:0] run_time_q;
	logic [EffTimeW-1:0] det_time_q;
	logic [LastW-1:0]    latest_q;

	// result registers
	logic [SumW-1:0]     res_sum_q;
	logic [ApscW-1:0]    res_apsc_q;
	logic [EffTimeW-1:0] res_time_q;
	logic [LastW-1:0]    res_last_q;
	logic [StmtW-1:0]    res_unc_q;

	// divider
	logic [DenW-1:0]    den_q;
	logic [DvdW-1:0]    dvd_q;
	logic [DvsW-1:0]    dvs_q;
	logic [DvsW-1:0]    rem_q;
	logic [QuotW-1:0]   quot_q;
	logic [DivCntW-1:0] div_cnt_q;

	logic                take;
	logic [PosW:0]       pos_plus;
	logic [19:0]         sum_wide;
	logic [SumW-1:0]     sum_new;
	logic [EffTimeW:0]   time_wide;
	logic [EffTimeW-1:0] run_time_new;
	logic [EffTimeW-1:0] det_time_new;
	logic [LastW-1:0]    latest_new;
	logic                has_fresh;
	logic [NumW-1:0]     den_plus_n;
	logic [NumW-1:0]     twos;
	logic [DvsW:0]       trial;
	logic                qbit;
	logic [QuotW-1:0]    quot_new;

	assign take = (state_q == B_RUN) && pop_valid;

	// per-test accumulate with saturation
	always_comb begin
		has_fresh    = (pop_item.fresh_count != '0);
		pos_plus     = {1'b0, pop_item.pos} + 1'b1;
		sum_wide     = 20'(sum_q) + 20'(pop_item.fresh_count) * 20'(pos_plus);
		sum_new      = has_fresh ? ((sum_wide > 20'(SumMax)) ? SumMax : sum_wide[SumW-1:0])
		                         : sum_q;
		time_wide    = {1'b0, run_time_q} + (EffTimeW+1)'(pop_item.time_val);
		run_time_new = time_wide[EffTimeW] ? TimeMax : time_wide[EffTimeW-1:0];
		det_time_new = (has_fresh || pop_item.pos == '0) ? run_time_new : det_time_q;
		latest_new   = has_fresh ? ((pop_item.pos > PosW'(LastMax)) ? LastMax
		                                                          : pop_item.pos[LastW-1:0])
		                         : latest_q;
	end

	// divider operands and one restoring step
	always_comb begin
		den_plus_n = NumW'(den_q) + NumW'(counts.n_eff);
		twos       = NumW'({res_sum_q, 1'b0});
		trial      = {rem_q, dvd_q[DvdW-1]};
		qbit       = (trial >= {1'b0, dvs_q});
		quot_new   = {quot_q[QuotW-2:0], qbit};
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			B_RUN: begin
				pop_ready = 1'b1;
				if (pop_valid && pop_item.last) begin
					state_d = B_PREP;
				end
			end
			B_PREP: begin
				state_d = B_SETUP;
			end
			B_SETUP: begin
				state_d = (twos >= den_plus_n) ? B_OUT : B_DIV;
			end
			B_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = B_RUN;
				end
			end
			default: begin
				state_d = B_RUN;
			end
		endcase
	end

	// accumulator state, cleared at reset and after each ordering
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			run_time_q <= '0;
			det_time_q <= '0;
			latest_q   <= '0;
		end else if (take) begin
			if (pop_item.last) begin
				sum_q      <= '0;
				run_time_q <= '0;
				det_time_q <= '0;
				latest_q   <= '0;
			end else begin
				sum_q      <= sum_new;
				run_time_q <= run_time_new;
				det_time_q <= det_time_new;
				latest_q   <= latest_new;
			end
		end
	end

	// result capture and APSC division
	always_ff @(posedge clk) begin
		if (take && pop_item.last) begin
			res_sum_q  <= sum_new;
			res_time_q <= det_time_new;
			res_last_q <= latest_new;
			res_unc_q  <= pop_item.uncovered;
		end
		case (state_q)
			B_PREP: begin
				den_q <= DenW'({18'(counts.n_eff) * 18'(counts.m_eff), 1'b0});
			end
			B_SETUP: begin
				res_apsc_q <= '0;
				dvd_q      <= {(den_plus_n - twos), 17'b0} + DvdW'(den_q);
				dvs_q      <= {den_q, 1'b0};
				rem_q      <= '0;
				quot_q     <= '0;
				div_cnt_q  <= DivCntW'(DvdW - 1);
			end
			B_DIV: begin
				dvd_q     <= {dvd_q[DvdW-2:0], 1'b0};
				rem_q     <= qbit ? DvsW'(trial - {1'b0, dvs_q}) : trial[DvsW-1:0];
				quot_q    <= quot_new;
				div_cnt_q <= div_cnt_q - 1'b1;
				if (div_cnt_q == '0) begin
					res_apsc_q <= (quot_new > QuotW'(ApscMax)) ? ApscMax : quot_new[ApscW-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign position_sum         = res_sum_q;
	assign apsc_value           = res_apsc_q;
	assign effective_time       = res_time_q;
	assign last_detect_position = res_last_q;
	assign uncovered_mask       = res_unc_q;

endmodule

// ----- design/coverage_first_detect_fitness.sv -----
// After the last test of an ordering is taken it passes the queue and the B_PREP and B_SETUP states,
// then the 38-step serial APSC divider (skipped when the score clamps to zero), before m_axis_tvalid rises.
// Throughput: one test per cycle while the four-entry queue has room; the back end stalls
// for the divider and until the result transaction is taken, then drains the queue.
// Reset: arst_n clears all tracking state and loads n = 64, m = 1024, all statements enabled.
// Depends on cfdf_pkg, cfdf_front, cfdf_fifo and cfdf_back.

module coverage_first_detect_fitness #(
	parameter int MAX_STATEMENTS = cfdf_pkg::MaxStatementsDef,
	parameter int MAX_TESTS      = cfdf_pkg::MaxTestsDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cfdf_pkg::CfgIndexW-1:0]  cfg_index,
	input  logic [cfdf_pkg::StmtW-1:0]      cfg_data,
	// test stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [cfdf_pkg::InDataW-1:0]    s_axis_tdata,  // coverage_bits[63:0], test_time[95:64]
	// result stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [cfdf_pkg::OutDataW-1:0]   m_axis_tdata   // position_sum[16:0], apsc_value[33:17],
	                                                       // effective_time[75:34],
	                                                       // last_detect_position[85:76],
	                                                       // uncovered_mask[149:86], zero pad
);

	import cfdf_pkg::*;

	localparam int QueueDepth = 4;

	logic [CntW-1:0]  stmt_count_q;
	logic [PosW-1:0]  test_count_q;
	logic [StmtW-1:0] stmt_enable_q;
	counts_t          counts;

	logic  push_valid;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop_ready;
	item_t pop_item;

	logic [SumW-1:0]     position_sum;
	logic [ApscW-1:0]    apsc_value;
	logic [EffTimeW-1:0] effective_time;
	logic [LastW-1:0]    last_detect_position;
	logic [StmtW-1:0]    uncovered_mask;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stmt_count_q  <= StmtCountRst;
			test_count_q  <= TestCountRst;
			stmt_enable_q <= StmtEnableRst;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index_t'(cfg_index))
				CFG_STMT_COUNT:  stmt_count_q  <= cfg_data[CntW-1:0];
				CFG_TEST_COUNT:  test_count_q  <= cfg_data[PosW-1:0];
				CFG_STMT_ENABLE: stmt_enable_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// clamp n and m into their legal ranges
	always_comb begin
		if (stmt_count_q == '0) begin
			counts.n_eff = CntW'(1);
		end else if (int'(stmt_count_q) > MAX_STATEMENTS) begin
			counts.n_eff = CntW'(MAX_STATEMENTS);
		end else begin
			counts.n_eff = stmt_count_q;
		end
		if (test_count_q == '0) begin
			counts.m_eff = PosW'(1);
		end else if (int'(test_count_q) > MAX_TESTS) begin
			counts.m_eff = PosW'(MAX_TESTS);
		end else begin
			counts.m_eff = test_count_q;
		end
	end

	cfdf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_axis_tvalid),
		.in_ready      (s_axis_tready),
		.coverage_bits (s_axis_tdata[StmtW-1:0]),
		.test_time     (s_axis_tdata[StmtW +: TimeInW]),
		.counts        (counts),
		.stmt_enable   (stmt_enable_q),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	cfdf_fifo #(
		.Width (ItemW),
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_item)
	);

	cfdf_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.pop_valid            (pop_valid),
		.pop_ready            (pop_ready),
		.pop_item             (pop_item),
		.counts               (counts),
		.out_valid            (m_axis_tvalid),
		.out_ready            (m_axis_tready),
		.position_sum         (position_sum),
		.apsc_value           (apsc_value),
		.effective_time       (effective_time),
		.last_detect_position (last_detect_position),
		.uncovered_mask       (uncovered_mask)
	);

	assign m_axis_tdata = {2'b00, uncovered_mask, last_detect_position, effective_time,
	                       apsc_value, position_sum};

endmodule

// ----- design/cfdf_checker.sv -----
// Port-level checks on the fitness block's result stream, bound to the top level.
// Depends on cfdf_pkg and coverage_first_detect_fitness.

module cfdf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [cfdf_pkg::OutDataW-1:0]   m_axis_tdata
);

	import cfdf_pkg::*;

	// a stalled result transaction stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result valid dropped while stalled");

	// a stalled result transaction keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result payload changed while stalled");

	// APSC never exceeds its saturation point
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[33:17] <= ApscMax))
		else $error("apsc_value above saturation");

	// an empty position sum means nothing was detected
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[16:0] == '0) |->
			(m_axis_tdata[149:86] == '1) && (m_axis_tdata[85:76] == '0))
		else $error("zero position sum with detected statements");

endmodule

bind coverage_first_detect_fitness cfdf_checker u_cfdf_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for coverage_first_detect_fitness: drives test transactions and
// register writes and checks every result against a cycle-free predictor of the APSC score.
// Depends on cfdf_pkg and the coverage_first_detect_fitness RTL.

module tb_top;
	import cfdf_pkg::*;

	localparam int          SettleCycles = 64;
	localparam int unsigned CycleLimit   = 1_000_000;
	localparam logic [CfgIndexW-1:0] CfgIndexSpare = 2'd3;

	// result transaction as packed in m_axis_tdata, msb first
	typedef struct packed {
		logic [1:0]          pad;
		logic [StmtW-1:0]    uncovered;
		logic [LastW-1:0]    last_pos;
		logic [EffTimeW-1:0] det_time;
		logic [ApscW-1:0]    apsc;
		logic [SumW-1:0]     pos_sum;
	} score_t;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CfgIndexW-1:0] cfg_index     = '0;
	logic [StmtW-1:0]     cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [InDataW-1:0]   s_axis_tdata  = '0;  // coverage_bits[63:0], test_time[95:64]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [OutDataW-1:0]  m_axis_tdata;        // position_sum, apsc_value, effective_time,
	                                           // last_detect_position, uncovered_mask, pad

	int          send_idle_pct = 38;
	int          recv_idle_pct = 80;
	int unsigned mismatches    = 0;
	int unsigned cycle_count   = 0;
	score_t      pending_scores [$];
	score_t      seen_score;
	score_t      want_score;

	// predictor registers and tracking state
	logic [CntW-1:0]     stmt_count_reg      = StmtCountRst;
	logic [PosW-1:0]     test_count_reg      = TestCountRst;
	logic [StmtW-1:0]    stmt_enable_reg     = StmtEnableRst;
	logic [StmtW-1:0]    covered_stmts       = '0;
	logic [PosW-1:0]     tests_seen          = '0;
	logic [EffTimeW-1:0] time_so_far         = '0;
	logic [EffTimeW-1:0] time_at_detect      = '0;
	logic [SumW-1:0]     detect_pos_sum      = '0;
	logic [LastW-1:0]    latest_first_detect = '0;

	coverage_first_detect_fitness DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// effective counts after clamping
	function automatic longint unsigned stmts_tracked();
		if (stmt_count_reg < 1) return 1;
		if (stmt_count_reg > MaxStatementsDef) return MaxStatementsDef;
		return stmt_count_reg;
	endfunction

	function automatic longint unsigned tests_per_ordering();
		if (test_count_reg < 1) return 1;
		if (test_count_reg > MaxTestsDef) return MaxTestsDef;
		return test_count_reg;
	endfunction

	// advance the score model by one test; queue a result at the end of an ordering
	function automatic void score_test(input logic [StmtW-1:0] cov, input logic [TimeInW-1:0] dur);
		logic [StmtW-1:0] tracked;
		logic [StmtW-1:0] fresh;
		longint unsigned  n, m, pos, acc, den, q;
		score_t           r;
		n = stmts_tracked();
		m = tests_per_ordering();
		tracked = stmt_enable_reg & ((n >= 64) ? {StmtW{1'b1}} : ((64'd1 << n) - 64'd1));
		fresh = cov & tracked & ~covered_stmts;
		pos = tests_seen;
		acc = time_so_far + dur;
		time_so_far = (acc > TimeMax) ? TimeMax : acc[EffTimeW-1:0];
		if (fresh != '0) begin
			acc = detect_pos_sum + $countones(fresh) * (pos + 1);
			detect_pos_sum = (acc > SumMax) ? SumMax : acc[SumW-1:0];
			covered_stmts = covered_stmts | fresh;
			latest_first_detect = (pos > LastMax) ? LastMax : pos[LastW-1:0];
		end
		if (fresh != '0 || pos == 0) time_at_detect = time_so_far;
		tests_seen = tests_seen + 1'b1;
		if (tests_seen < m) return;
		// APSC = (2nm + n - 2S) / (2nm) in Q1.16, rounded half up
		den = 2 * n * m;
		acc = 2 * detect_pos_sum;
		if (acc >= den + n) begin
			q = 0;
		end else begin
			q = ((den + n - acc) * 131072 + den) / (2 * den);
			if (q > ApscMax) q = ApscMax;
		end
		r.pad       = '0;
		r.pos_sum   = detect_pos_sum;
		r.apsc      = q[ApscW-1:0];
		r.det_time  = time_at_detect;
		r.last_pos  = latest_first_detect;
		r.uncovered = ~covered_stmts;
		pending_scores.push_back(r);
		covered_stmts       = '0;
		tests_seen          = '0;
		time_so_far         = '0;
		time_at_detect      = '0;
		detect_pos_sum      = '0;
		latest_first_detect = '0;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected %0h, got %0h", what, want, got);
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_score = m_axis_tdata;
			if (pending_scores.size() == 0) begin
				flag_mismatch("unexpected result", '0, seen_score.pos_sum);
			end else begin
				want_score = pending_scores.pop_front();
				if (seen_score.pos_sum != want_score.pos_sum)
					flag_mismatch("position_sum", want_score.pos_sum, seen_score.pos_sum);
				if (seen_score.apsc != want_score.apsc)
					flag_mismatch("apsc_value", want_score.apsc, seen_score.apsc);
				if (seen_score.det_time != want_score.det_time)
					flag_mismatch("effective_time", want_score.det_time, seen_score.det_time);
				if (seen_score.last_pos != want_score.last_pos)
					flag_mismatch("last_detect_position", want_score.last_pos,
						seen_score.last_pos);
				if (seen_score.uncovered != want_score.uncovered)
					flag_mismatch("uncovered_mask", want_score.uncovered, seen_score.uncovered);
				if (seen_score.pad != want_score.pad)
					flag_mismatch("padding", want_score.pad, seen_score.pad);
			end
		end
	end

	// one register write transaction; cfg_valid stays high for a following write
	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [StmtW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_STMT_COUNT:  stmt_count_reg  = val[CntW-1:0];
			CFG_TEST_COUNT:  test_count_reg  = val[PosW-1:0];
			CFG_STMT_ENABLE: stmt_enable_reg = val;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		cfg_valid <= 1'b0;
	endtask

	task automatic set_counts(input logic [CntW-1:0] n, input logic [PosW-1:0] m,
			input logic [StmtW-1:0] en);
		write_reg(CFG_STMT_COUNT, StmtW'(n));
		write_reg(CFG_TEST_COUNT, StmtW'(m));
		write_reg(CFG_STMT_ENABLE, en);
		end_writes();
	endtask

	// one test transaction, with random sender gaps
	task automatic send_test(input logic [StmtW-1:0] cov, input logic [TimeInW-1:0] dur);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {dur, cov};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		score_test(cov, dur);
	endtask

	// hold off the sender until all results are in and the back end has settled
	task automatic wait_until_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_scores.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	function automatic logic [StmtW-1:0] pick_coverage();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return 64'd1 << $urandom_range(0, 63);
			4, 5, 6: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [TimeInW-1:0] pick_time();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_tests(input int count, input int hit_pct);
		for (int i = 0; i < count; i++) begin
			send_test(($urandom_range(0, 99) < hit_pct) ? pick_coverage() : '0, pick_time());
		end
	endtask

	task automatic randomize_settings();
		logic [StmtW-1:0] word;
		logic [StmtW-1:0] en;
		word = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0:       word[CntW-1:0] = '0;
			1:       word[CntW-1:0] = '1;
			2:       word[CntW-1:0] = 7'd64;
			default: word[CntW-1:0] = CntW'($urandom_range(1, 64));
		endcase
		write_reg(CFG_STMT_COUNT, word);
		word = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0:       word[PosW-1:0] = '0;
			1:       word[PosW-1:0] = 11'd1;
			2:       word[PosW-1:0] = PosW'($urandom_range(20, 40));
			default: word[PosW-1:0] = PosW'($urandom_range(2, 10));
		endcase
		write_reg(CFG_TEST_COUNT, word);
		case ($urandom_range(0, 7))
			0, 1, 2, 3: en = '1;
			4, 5:       en = {$urandom, $urandom};
			default:    en = {$urandom, $urandom} & {$urandom, $urandom};
		endcase
		write_reg(CFG_STMT_ENABLE, en);
		if ($urandom_range(0, 4) == 0) write_reg(CfgIndexSpare, {$urandom, $urandom});
		end_writes();
	endtask

	// first half of an ordering at reset values: n = 64, m = 1024, all statements tracked
	task automatic test_reset_defaults();
		send_random_tests(512, 3);
	endtask

	// test_count above the maximum clamps to 1024; finishes the ordering begun at reset
	task automatic test_clamped_long_ordering();
		wait_until_idle();
		set_counts(7'd64, 11'd2047, '1);
		send_random_tests(512, 3);
	endtask

	// all-zero and all-one fields, all statements hit at once
	task automatic test_field_extremes();
		wait_until_idle();
		set_counts(7'd64, 11'd4, '1);
		send_test('0, '0);
		send_test('1, '1);
		send_test('1, 32'd1);
		send_test(64'h8000_0000_0000_0001, '1);
	endtask

	// counts out of range are clamped
	task automatic test_count_clamps();
		wait_until_idle();
		set_counts(7'd0, 11'd0, '1);
		send_test('1, 32'd7);
		send_test(64'h2, 32'd9);
		wait_until_idle();
		set_counts(7'd127, 11'd2, '1);
		send_test(64'hFFFF_0000_0000_0000, 32'd3);
		send_test('1, '1);
	endtask

	// nothing detected: effective time is the first test's time
	task automatic test_no_detection();
		wait_until_idle();
		set_counts(7'd8, 11'd3, '1);
		send_test(64'hFF00, 32'd1234);
		send_test('0, '1);
		send_test(64'hF000_0000_0000_0000, 32'd55);
	endtask

	// disabled statements and those above n stay uncovered
	task automatic test_disabled_statements();
		wait_until_idle();
		set_counts(7'd40, 11'd4, 64'h5555_AAAA_0F0F_F0F0);
		send_test(64'h0000_0001_0000_0001, 32'd10);
		send_test(64'hFFFF_FFFF_0000_0000, 32'd20);
		send_test('0, 32'd30);
		send_test('1, 32'd40);
	endtask

	// shorten the ordering below the tests already taken
	task automatic test_midway_count_change();
		wait_until_idle();
		set_counts(7'd5, 11'd2047, '1);
		for (int i = 0; i < 8; i++) send_test(64'd1 << i, pick_time());
		wait_until_idle();
		write_reg(CFG_TEST_COUNT, 64'd3);
		end_writes();
		send_test(64'h1F, 32'd77);
	endtask

	// a write to the unused index changes nothing
	task automatic test_spare_index();
		wait_until_idle();
		set_counts(7'd16, 11'd2, '1);
		write_reg(CfgIndexSpare, '0);
		end_writes();
		send_test(64'hFF, 32'd5);
		send_test(64'hFF00, 32'd6);
	endtask

	// random orderings under fresh settings, sometimes leaving one unfinished
	task automatic test_random_orderings(input int send_pct, input int recv_pct, input int budget);
		int sent;
		int burst;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		sent = 0;
		while (sent < budget) begin
			wait_until_idle();
			randomize_settings();
			burst = int'(tests_per_ordering()) * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0)
				burst = burst + $urandom_range(1, int'(tests_per_ordering()));
			send_random_tests(burst, 70);
			sent = sent + burst;
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_clamped_long_ordering();
		test_field_extremes();
		test_count_clamps();
		test_no_detection();
		test_disabled_statements();
		test_midway_count_change();
		test_spare_index();
		test_random_orderings(38, 80, 40);
		test_random_orderings(80, 38, 40);
		test_random_orderings(0, 0, 40);
		wait_until_idle();
		if (mismatches == 0 && pending_scores.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
